// File: hw/rtl/wklp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wklp_pkg
// Shared types and constants of the wireless keyboard link parser.
// ----------------------------------------------------------------------------
package wklp_pkg;

  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_KEY_END = 8'hEF;
  localparam logic [7:0] BYTE_LED_REQ = 8'hFE;
  localparam logic [7:0] LED_CONN     = 8'h0F;

  localparam logic [7:0] SRC_NONE  = 8'h00;
  localparam logic [7:0] SRC_KEYS  = 8'h01;
  localparam logic [7:0] SRC_CONN  = 8'h02;
  localparam logic [7:0] SRC_DISC  = 8'h03;
  localparam logic [7:0] SRC_ERROR = 8'h04;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  localparam logic FUNC_RX  = 1'b0;
  localparam logic FUNC_LED = 1'b1;

  // Prefixes, left aligned in 13 characters.
  localparam logic [103:0] READY_STR = {"+READY", 56'h0};
  localparam logic [103:0] CONN_STR  = {"+CONNECTED", 24'h0};
  localparam logic [103:0] DISC_STR  = "+DISCONNECTED";
  localparam logic [103:0] ADV_STR   = {"+ADVERTISING", 8'h0};

  localparam logic [3:0] READY_LEN = 4'd6;
  localparam logic [3:0] CONN_LEN  = 4'd10;
  localparam logic [3:0] DISC_LEN  = 4'd13;
  localparam logic [3:0] ADV_LEN   = 4'd12;

  localparam logic [3:0] SCAN_LAST_SHORT = 4'd5;
  localparam logic [3:0] SCAN_LAST_LONG  = 4'd12;
  localparam logic [3:0] SCAN_LAST_KEY   = 4'd6;

  localparam logic [3:0] SHORT_LINE_LEN = 4'd8;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       scan_key;
    logic       decide;
    logic       load_rpt;
    logic       load_led;
    logic       load_cr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_led;
    logic led_change;
    logic is_cr;
    logic is_key;
    logic is_req;
    logic short_line;
    logic src_none;
  } dp_status_t;

  function automatic logic [7:0] char_at(logic [103:0] s, logic [3:0] idx);
    logic [3:0] pos;
    pos = 4'd12 - idx;
    return s[{pos, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wklp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wklp_datapath
// Line memory, cursor, prefix match flags, report store, LED state and
// the output register.
// ----------------------------------------------------------------------------
module wklp_datapath #(
  parameter int LINE_DEPTH = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_func_i,
  input  wire  [7:0]             in_value_i,
  input  wklp_pkg::ctrl_cmd_t    cmd_i,
  output wklp_pkg::dp_status_t   status_o,
  output logic                   out_kind_o,
  output logic [63:0]            out_report_o,
  output logic [7:0]             out_tx_o,
  output logic                   out_last_o
);
  import wklp_pkg::*;

  localparam int CW = $clog2(LINE_DEPTH);

  logic [7:0]    line_mem [LINE_DEPTH];
  logic [7:0]    rd_data_q;
  logic          rd_vld_q;
  logic [3:0]    rd_idx_q;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [7:0]    led_q, led_d;
  logic [7:0]    report_q [8];
  logic          rdy_ok_q, rdy_ok_d, conn_ok_q, conn_ok_d;
  logic          disc_ok_q, disc_ok_d, adv_ok_q, adv_ok_d;
  logic [7:0]    src;
  logic          rx_accept;
  logic [CW-1:0] idx_ext;
  logic [2:0]    rpt_idx;

  assign rx_accept = cmd_i.accept && (in_func_i == FUNC_RX);
  assign idx_ext   = CW'(rd_idx_q);
  assign rpt_idx   = rd_idx_q[2:0] + 3'd1;

  assign status_o.is_led     = (in_func_i == FUNC_LED);
  assign status_o.led_change = (in_value_i != led_q);
  assign status_o.is_cr      = (in_value_i == BYTE_CR);
  assign status_o.is_key     = (in_value_i == BYTE_KEY_END);
  assign status_o.is_req     = (in_value_i == BYTE_LED_REQ);
  assign status_o.short_line = (cursor_q < CW'(SHORT_LINE_LEN));
  assign status_o.src_none   = (src == SRC_NONE);

  always_comb begin
    priority if (cursor_q < CW'(SHORT_LINE_LEN)) begin
      src = (rdy_ok_q && cursor_q >= CW'(READY_LEN)) ? SRC_NONE : SRC_ERROR;
    end else if (conn_ok_q && cursor_q >= CW'(CONN_LEN)) begin
      src = SRC_CONN;
    end else if (disc_ok_q && cursor_q >= CW'(DISC_LEN)) begin
      src = SRC_DISC;
    end else if (adv_ok_q && cursor_q >= CW'(ADV_LEN)) begin
      src = SRC_NONE;
    end else begin
      src = SRC_ERROR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      line_mem[cursor_q] <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= line_mem[CW'(cmd_i.rd_addr)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_idx_q <= cmd_i.rd_addr;
    end
  end

  always_comb begin
    rdy_ok_d  = rdy_ok_q;
    conn_ok_d = conn_ok_q;
    disc_ok_d = disc_ok_q;
    adv_ok_d  = adv_ok_q;
    if (cmd_i.accept) begin
      rdy_ok_d  = 1'b1;
      conn_ok_d = 1'b1;
      disc_ok_d = 1'b1;
      adv_ok_d  = 1'b1;
    end else if (rd_vld_q && !cmd_i.scan_key) begin
      if (rd_idx_q < READY_LEN && rd_data_q != char_at(READY_STR, rd_idx_q)) begin
        rdy_ok_d = 1'b0;
      end
      if (rd_idx_q < CONN_LEN && rd_data_q != char_at(CONN_STR, rd_idx_q)) begin
        conn_ok_d = 1'b0;
      end
      if (rd_idx_q < DISC_LEN && rd_data_q != char_at(DISC_STR, rd_idx_q)) begin
        disc_ok_d = 1'b0;
      end
      if (rd_idx_q < ADV_LEN && rd_data_q != char_at(ADV_STR, rd_idx_q)) begin
        adv_ok_d = 1'b0;
      end
    end
  end

  always_comb begin
    cursor_d = cursor_q;
    led_d    = led_q;
    if (cmd_i.accept && in_func_i == FUNC_LED) begin
      led_d = in_value_i;
    end
    if (rx_accept) begin
      priority if (status_o.is_cr || status_o.is_key) begin
        cursor_d = cursor_q;
      end else if (status_o.is_req) begin
        cursor_d = '0;
      end else if (cursor_q != CW'(LINE_DEPTH - 1)) begin
        cursor_d = cursor_q + CW'(1);
      end else begin
        cursor_d = cursor_q;
      end
    end
    if (cmd_i.decide) begin
      cursor_d = '0;
      if (!cmd_i.scan_key && src == SRC_CONN) begin
        led_d = LED_CONN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= '0;
      led_q     <= '0;
      rdy_ok_q  <= 1'b0;
      conn_ok_q <= 1'b0;
      disc_ok_q <= 1'b0;
      adv_ok_q  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        report_q[i] <= '0;
      end
    end else begin
      cursor_q  <= cursor_d;
      led_q     <= led_d;
      rdy_ok_q  <= rdy_ok_d;
      conn_ok_q <= conn_ok_d;
      disc_ok_q <= disc_ok_d;
      adv_ok_q  <= adv_ok_d;
      if (rd_vld_q && cmd_i.scan_key) begin
        if (rd_idx_q == 4'd0) begin
          report_q[0] <= rd_data_q;
        end else if (idx_ext < cursor_q) begin
          report_q[rpt_idx] <= rd_data_q;
        end
      end
      if (cmd_i.decide) begin
        if (cmd_i.scan_key) begin
          report_q[1] <= SRC_KEYS;
        end else if (src != SRC_NONE) begin
          report_q[1] <= src;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rpt) begin
      out_kind_o   <= KIND_REPORT;
      out_report_o <= {report_q[7], report_q[6], report_q[5], report_q[4],
                       report_q[3], report_q[2], report_q[1], report_q[0]};
      out_tx_o     <= '0;
      out_last_o   <= 1'b1;
    end else if (cmd_i.load_led) begin
      out_kind_o   <= KIND_TX;
      out_report_o <= '0;
      out_tx_o     <= led_q;
      out_last_o   <= 1'b0;
    end else if (cmd_i.load_cr) begin
      out_kind_o   <= KIND_TX;
      out_report_o <= '0;
      out_tx_o     <= BYTE_CR;
      out_last_o   <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wklp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wklp_ctrl
// Sequencer: accepts items, runs the line memory scan and issues the
// output register loads.
// ----------------------------------------------------------------------------
module wklp_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire                    out_ready_i,
  output logic                   out_valid_o,
  input  wklp_pkg::dp_status_t   status_i,
  output wklp_pkg::ctrl_cmd_t    cmd_o
);
  import wklp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_WAIT     = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_EMIT_RPT = 3'd4;
  localparam logic [2:0] S_EMIT_LED = 3'd5;
  localparam logic [2:0] S_EMIT_CR  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [3:0] last_q, last_d;
  logic       key_q, key_d;
  logic       out_vld_q, out_vld_d;
  logic       out_free;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_ready_o && in_valid_i;
  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    last_d         = last_q;
    key_d          = key_q;
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.scan_key = key_q;
    cmd_o.rd_addr  = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          priority if (status_i.is_led) begin
            if (status_i.led_change) begin
              state_d = S_EMIT_LED;
            end
          end else if (status_i.is_cr) begin
            key_d   = 1'b0;
            last_d  = status_i.short_line ? SCAN_LAST_SHORT : SCAN_LAST_LONG;
            state_d = S_SCAN;
          end else if (status_i.is_key) begin
            key_d   = 1'b1;
            last_d  = SCAN_LAST_KEY;
            state_d = S_SCAN;
          end else if (status_i.is_req) begin
            state_d = S_EMIT_LED;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_q + 4'd1;
        if (cnt_q == last_q) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = (key_q || !status_i.src_none) ? S_EMIT_RPT : S_IDLE;
      end
      S_EMIT_RPT: begin
        if (out_free) begin
          cmd_o.load_rpt = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_EMIT_LED: begin
        if (out_free) begin
          cmd_o.load_led = 1'b1;
          state_d        = S_EMIT_CR;
        end
      end
      S_EMIT_CR: begin
        if (out_free) begin
          cmd_o.load_cr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_rpt || cmd_o.load_led || cmd_o.load_cr) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      last_q    <= '0;
      key_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      key_q     <= key_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wireless_keyboard_link_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wireless_keyboard_link_parser_unit
// Parses the radio keyboard module's serial bytes and host LED writes into
// key and status reports for the host and LED bytes for the module.
// ----------------------------------------------------------------------------
// An ordinary line byte and an unchanged LED write leave the block idle,
// so it is ready again in the next cycle. A status line end reads the
// first 6 (line under 8 bytes) or 13 stored bytes from the line memory,
// one per cycle, then passes a wait and a decide state and loads a report
// unless the line names no reporting source. A key frame end reads 7 bytes
// and always loads a report. An LED request or a changed LED write gives
// two transfers, LED byte then CR. Every load waits while the receiver stalls.
// A result waits in the output register while the next item is accepted.
// The line memory needs no clearing after reset.
module wireless_keyboard_link_parser_unit #(
  parameter int LINE_DEPTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,  // value
  input  wire  [0:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,  // report_modifier, report_source, key_a..key_f, tx_byte
  output logic [0:0]  m_axis_tuser,  // out_kind
  output logic        m_axis_tlast   // last
);
  import wklp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [63:0] out_report;
  logic [7:0]  out_tx;

  wklp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wklp_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_func_i    (s_axis_tuser[0]),
    .in_value_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_kind_o   (m_axis_tuser[0]),
    .out_report_o (out_report),
    .out_tx_o     (out_tx),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_tx, out_report};

`ifndef SYNTHESIS
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == FUNC_RX &&
     s_axis_tdata == BYTE_LED_REQ) |=> !s_axis_tready)
    else $error("LED request did not start a transfer pair");

  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0] == KIND_TX) |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("module byte carries report bytes");

  a_rpt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0] == KIND_REPORT) |->
      (m_axis_tlast && m_axis_tdata[71:64] == 8'd0 && m_axis_tdata[15:8] != SRC_NONE))
    else $error("report transfer malformed");
`endif

endmodule
`default_nettype wire
